@@ hw/rtl/b32b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b32b64_pkg
// shared types, character codes and lookup functions for the base32 to
// base64 transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b32b64_pkg;

    // default number of quantum entries between front and back
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int QUANTUM_W = 40;
    localparam int NBYTES_W  = 3;

    // ascii codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_2 = 8'h32;
    localparam logic [7:0] CH_DIGIT_7 = 8'h37;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // one finished 40-bit quantum and how many of its bytes count
    typedef struct packed {
        logic [QUANTUM_W-1:0] bits;
        logic [NBYTES_W-1:0]  nbytes;
        logic                 last;
    } quantum_t;

    typedef enum logic [0:0] {
        BK_BYTES,
        BK_EMIT
    } back_state_t;

    // pad count of a quantum to number of valid bytes
    function automatic logic [NBYTES_W-1:0] keep_bytes(input logic [3:0] pads);
        logic [NBYTES_W-1:0] nb;
        unique case (pads)
            4'd6:    nb = 3'd1;
            4'd4:    nb = 3'd2;
            4'd3:    nb = 3'd3;
            4'd1:    nb = 3'd4;
            default: nb = 3'd5;
        endcase
        return nb;
    endfunction

    // six-bit value to base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] ch;
        w = {2'b00, v};
        if (v < 6'd26)
            ch = CH_UPPER_A + w;
        else if (v < 6'd52)
            ch = CH_LOWER_A + (w - 8'd26);
        else if (v < 6'd62)
            ch = CH_DIGIT_0 + (w - 8'd52);
        else if (v == 6'd62)
            ch = CH_PLUS;
        else
            ch = CH_SLASH;
        return ch;
    endfunction

endpackage

@@ hw/rtl/base32_to_base64_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// base32_to_base64_transcoder_core
// the back end puts out one base64 character per cycle while a group drains
// and the receiver does not stall; between groups it moves the bytes of each
// quantum into the carry one at a time and emits no new character;
// the front end takes one base32 character per cycle until the queue fills
// reset: asynchronous active low, clears quantum, carry and queue state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base32_to_base64_transcoder_core
    import b32b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    // base32 character transfers
    input  logic      b32_valid,
    output logic      b32_stall,
    input  in_item_t  b32_data,
    // base64 character transfers
    output logic      b64_valid,
    input  logic      b64_stall,
    output out_item_t b64_data
);

    // front to queue
    logic     q_push;
    quantum_t q_wdata;
    logic     q_full;
    // queue to back
    logic     q_valid;
    quantum_t q_rdata;
    logic     q_pop;

    // front: decode each character, shift it into the quantum, and hand a
    // finished quantum (eight characters or end of message) to the queue
    // with its valid byte count already worked out from the pad count
    b32b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .b32_valid (b32_valid),
        .b32_stall (b32_stall),
        .b32_data  (b32_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // queue: decouples the front, which takes a character at a time, from the
    // back, which works through each quantum byte by byte and group by group
    b32b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_rdata),
        .pop   (q_pop)
    );

    // back: one byte a cycle into the carry while a quantum waits and no group
    // drains; every third byte (or the end of the message) loads a 24-bit group
    // that drains as four characters through the output register
    b32b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .b64_valid (b64_valid),
        .b64_stall (b64_stall),
        .b64_data  (b64_data)
    );

`ifndef SYNTHESIS
    // every quantum keeps between one and five bytes
    a_nbytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_wdata.nbytes >= 3'd1 && q_wdata.nbytes <= 3'd5))
        else $error("quantum byte count out of range");

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty quantum queue");

    // the final character of a message always closes a quantum
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (b32_valid && !b32_stall && b32_data.in_last) |-> q_push)
        else $error("final character did not close a quantum");
`endif

endmodule

@@ hw/rtl/b32b64_front.sv @@
// ----------------------------------------------------------------------------
// b32b64_front
// decodes base32 characters and packs them into 40-bit quanta
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b32b64_front
    import b32b64_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     b32_valid,
    output logic     b32_stall,
    input  in_item_t b32_data,
    input  logic     q_full,
    output logic     q_push,
    output quantum_t q_wdata
);

    logic [QUANTUM_W-1:0] bits_reg,  bits_next;
    logic [2:0]           chars_reg, chars_next;
    logic [3:0]           pads_reg,  pads_next;

    logic                 accept;
    logic                 is_letter;
    logic                 is_digit;
    logic [4:0]           val;
    logic [QUANTUM_W-1:0] bits_new;
    logic [3:0]           chars_new;
    logic [3:0]           pads_new;
    logic [3:0]           fill;
    logic [5:0]           shamt;
    logic                 done;

    assign b32_stall = q_full;
    assign accept    = b32_valid && !q_full;

    always_comb
    begin
        is_letter = (b32_data.in_char >= CH_UPPER_A) && (b32_data.in_char <= CH_UPPER_Z);
        is_digit  = (b32_data.in_char >= CH_DIGIT_2) && (b32_data.in_char <= CH_DIGIT_7);
        priority if (is_letter)
            val = 5'(b32_data.in_char - CH_UPPER_A);
        else if (is_digit)
            val = 5'(b32_data.in_char - CH_DIGIT_2 + 8'd26);
        else
            val = 5'd0;

        bits_new  = {bits_reg[QUANTUM_W-6:0], val};
        chars_new = {1'b0, chars_reg} + 4'd1;
        pads_new  = pads_reg + {3'b000, !(is_letter || is_digit)};
        done      = (chars_new == 4'd8) || b32_data.in_last;

        // missing characters of a short quantum count as pads
        fill  = 4'd8 - chars_new;
        shamt = {fill, 2'b00} + {2'b00, fill};

        q_push         = accept && done;
        q_wdata.bits   = bits_new << shamt;
        q_wdata.nbytes = keep_bytes(pads_new + fill);
        q_wdata.last   = b32_data.in_last;

        bits_next  = bits_reg;
        chars_next = chars_reg;
        pads_next  = pads_reg;
        if (accept)
        begin
            if (done)
            begin
                bits_next  = '0;
                chars_next = '0;
                pads_next  = '0;
            end
            else
            begin
                bits_next  = bits_new;
                chars_next = chars_new[2:0];
                pads_next  = pads_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            chars_reg <= '0;
            pads_reg  <= '0;
        end
        else
        begin
            bits_reg  <= bits_next;
            chars_reg <= chars_next;
            pads_reg  <= pads_next;
        end
    end

endmodule

@@ hw/rtl/b32b64_queue.sv @@
// ----------------------------------------------------------------------------
// b32b64_queue
// small register fifo of finished quanta between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b32b64_queue
    import b32b64_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  quantum_t wdata,
    output logic     full,
    output logic     valid,
    output quantum_t rdata,
    input  logic     pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    quantum_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ hw/rtl/b32b64_back.sv @@
// ----------------------------------------------------------------------------
// b32b64_back
// walks the bytes of each quantum, groups them in threes and emits base64
// characters through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b32b64_back
    import b32b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  quantum_t  q_rdata,
    output logic      q_pop,
    output logic      b64_valid,
    input  logic      b64_stall,
    output out_item_t b64_data
);

    back_state_t      state_reg, state_next;
    logic [2:0]       byte_idx_reg, byte_idx_next;
    logic [15:0]      carry_bytes_reg, carry_bytes_next;
    logic [1:0]       carry_count_reg, carry_count_next;
    logic [23:0]      grp_reg, grp_next;
    logic [1:0]       slot_reg, slot_next;
    logic [2:0]       data_slots_reg, data_slots_next;
    logic             grp_last_reg, grp_last_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [7:0]       cur_byte;
    logic             final_byte;
    logic             grp_load;
    logic             out_ready;
    logic             emit_fire;
    logic [5:0]       slot_val;
    logic [1:0]       cnt_new;

    assign out_ready = !out_valid_reg || !b64_stall;
    assign emit_fire = (state_reg == BK_EMIT) && out_ready;
    assign b64_valid = out_valid_reg;
    assign b64_data  = out_item_reg;

    // byte and slot decode
    always_comb
    begin
        unique case (byte_idx_reg)
            3'd0:    cur_byte = q_rdata.bits[39:32];
            3'd1:    cur_byte = q_rdata.bits[31:24];
            3'd2:    cur_byte = q_rdata.bits[23:16];
            3'd3:    cur_byte = q_rdata.bits[15:8];
            default: cur_byte = q_rdata.bits[7:0];
        endcase
        final_byte = (byte_idx_reg == q_rdata.nbytes - 3'd1);
        grp_load   = (carry_count_reg == 2'd2) || (q_rdata.last && final_byte);
        cnt_new    = carry_count_reg + 2'd1;

        unique case (slot_reg)
            2'd0: slot_val = grp_reg[23:18];
            2'd1: slot_val = grp_reg[17:12];
            2'd2: slot_val = grp_reg[11:6];
            2'd3: slot_val = grp_reg[5:0];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_BYTES:
            begin
                if (q_valid && grp_load)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_ready && (slot_reg == 2'd3))
                    state_next = BK_BYTES;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop            = 1'b0;
        byte_idx_next    = byte_idx_reg;
        carry_bytes_next = carry_bytes_reg;
        carry_count_next = carry_count_reg;
        grp_next         = grp_reg;
        slot_next        = slot_reg;
        data_slots_next  = data_slots_reg;
        grp_last_next    = grp_last_reg;
        out_item_next    = out_item_reg;
        out_valid_next   = b64_stall ? out_valid_reg : 1'b0;

        unique case (state_reg)
            BK_BYTES:
            begin
                if (q_valid)
                begin
                    q_pop         = final_byte;
                    byte_idx_next = final_byte ? 3'd0 : byte_idx_reg + 3'd1;
                    if (carry_count_reg == 2'd2)
                    begin
                        // full group of three bytes
                        grp_next         = {carry_bytes_reg, cur_byte};
                        data_slots_next  = 3'd4;
                        grp_last_next    = q_rdata.last && final_byte;
                        carry_bytes_next = '0;
                        carry_count_next = '0;
                        slot_next        = '0;
                    end
                    else if (q_rdata.last && final_byte)
                    begin
                        // short final group, zero filled
                        if (cnt_new == 2'd1)
                            grp_next = {cur_byte, 16'h0000};
                        else
                            grp_next = {carry_bytes_reg[7:0], cur_byte, 8'h00};
                        data_slots_next  = {1'b0, cnt_new} + 3'd1;
                        grp_last_next    = 1'b1;
                        carry_bytes_next = '0;
                        carry_count_next = '0;
                        slot_next        = '0;
                    end
                    else
                    begin
                        carry_bytes_next = {carry_bytes_reg[7:0], cur_byte};
                        carry_count_next = cnt_new;
                    end
                end
            end
            BK_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b1;
                    if ({1'b0, slot_reg} < data_slots_reg)
                        out_item_next.out_char = b64_char(slot_val);
                    else
                        out_item_next.out_char = CH_EQUALS;
                    out_item_next.out_last = grp_last_reg && (slot_reg == 2'd3);
                    slot_next              = slot_reg + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_BYTES;
            byte_idx_reg    <= '0;
            carry_bytes_reg <= '0;
            carry_count_reg <= '0;
            slot_reg        <= '0;
            data_slots_reg  <= '0;
            grp_last_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_idx_reg    <= byte_idx_next;
            carry_bytes_reg <= carry_bytes_next;
            carry_count_reg <= carry_count_next;
            slot_reg        <= slot_next;
            data_slots_reg  <= data_slots_next;
            grp_last_reg    <= grp_last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        out_item_reg <= out_item_next;
    end

endmodule

@@ tb/base32_to_base64_transcoder_core_test.sv @@
// ----------------------------------------------------------------------------
// base32_to_base64_transcoder_core_test
// self-checking bench for the base32 to base64 transcoder: a cycle-free
// model of the transcoder predicts every base64 character of each accepted
// base32 character, and a monitor compares the output transfers in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base32_to_base64_transcoder_core_test;
    import b32b64_pkg::*;

    // receiver hold-off length for the backpressure test
    localparam int HOLD_CYCLES = 300;
    // settle time after the last expected character
    localparam int DRAIN_CYCLES = 40;

    logic      clk;
    logic      rst_n;
    logic      b32_valid;
    logic      b32_stall;
    in_item_t  b32_data;
    logic      b64_valid;
    logic      b64_stall;
    out_item_t b64_data;

    // six-bit value to base64 character
    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // transcoder model state
    logic [39:0] qnt_bits;
    int          qnt_chars;
    int          qnt_pads;
    logic [15:0] carry_bytes;
    int          carry_count;
    logic [7:0]  step_chars[$];

    // base64 characters still owed by the block, oldest first
    out_item_t   expected_b64[$];

    // idling and hold-off controls shared with the receiver process
    bit          idle_on;
    int          hold_left;
    int          stall_left;

    int          error_count;
    int          chars_sent;
    int          messages_sent;
    int          results_checked;

    base32_to_base64_transcoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .b32_valid (b32_valid),
        .b32_stall (b32_stall),
        .b32_data  (b32_data),
        .b64_valid (b64_valid),
        .b64_stall (b64_stall),
        .b64_data  (b64_data)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous run limit, far above the slowest correct run
    initial
    begin
        #3_000_000;
        $display("base32_to_base64_transcoder_core_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // transcoder model
    // ------------------------------------------------------------------

    function automatic bit is_b32_char(input logic [7:0] ch);
        return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
               (ch >= CH_DIGIT_2 && ch <= CH_DIGIT_7);
    endfunction

    function void clear_transcoder_state();
        qnt_bits    = '0;
        qnt_chars   = 0;
        qnt_pads    = 0;
        carry_bytes = '0;
        carry_count = 0;
    endfunction

    function void emit_b64(input logic [5:0] v);
        step_chars.push_back(b64_alphabet[v]);
    endfunction

    // a byte either waits in the carry or completes a group of three
    function void take_byte(input logic [7:0] b);
        logic [23:0] grp;
        if (carry_count == 2)
        begin
            grp = {carry_bytes, b};
            emit_b64(grp[23:18]);
            emit_b64(grp[17:12]);
            emit_b64(grp[11:6]);
            emit_b64(grp[5:0]);
            carry_bytes = '0;
            carry_count = 0;
        end
        else
        begin
            carry_bytes = {carry_bytes[7:0], b};
            carry_count++;
        end
    endfunction

    // advance the model by one base32 character and queue what it causes
    task predict_base64(input logic [7:0] ch, input logic last);
        logic [4:0]  val;
        logic [23:0] grp;
        int          nb;
        out_item_t   item;
        step_chars.delete();
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            val = 5'(ch - CH_UPPER_A);
        else if (ch >= CH_DIGIT_2 && ch <= CH_DIGIT_7)
            val = 5'(ch - CH_DIGIT_2 + 8'd26);
        else
        begin
            // anything outside the alphabet is padding
            val = '0;
            qnt_pads++;
        end
        qnt_bits = {qnt_bits[34:0], val};
        qnt_chars++;

        if (qnt_chars >= 8 || last)
        begin
            // a short final quantum is filled out with pads
            while (qnt_chars < 8)
            begin
                qnt_bits = {qnt_bits[34:0], 5'd0};
                qnt_pads++;
                qnt_chars++;
            end
            case (qnt_pads)
                6:       nb = 1;
                4:       nb = 2;
                3:       nb = 3;
                1:       nb = 4;
                default: nb = 5;
            endcase
            for (int i = 0; i < nb; i++)
                take_byte(qnt_bits[39 - 8 * i -: 8]);
            qnt_bits  = '0;
            qnt_chars = 0;
            qnt_pads  = 0;
        end

        if (last)
        begin
            // zero-filled final group plus '=' padding
            if (carry_count == 1)
            begin
                grp = {carry_bytes[7:0], 16'd0};
                emit_b64(grp[23:18]);
                emit_b64(grp[17:12]);
                step_chars.push_back(CH_EQUALS);
                step_chars.push_back(CH_EQUALS);
            end
            else if (carry_count == 2)
            begin
                grp = {carry_bytes, 8'd0};
                emit_b64(grp[23:18]);
                emit_b64(grp[17:12]);
                emit_b64(grp[11:6]);
                step_chars.push_back(CH_EQUALS);
            end
            clear_transcoder_state();
        end

        foreach (step_chars[i])
        begin
            item.out_char = step_chars[i];
            item.out_last = last && (i == step_chars.size() - 1);
            expected_b64.push_back(item);
        end
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one base32 transfer, with an optional idle burst in front of it
    task send_char(input logic [7:0] ch, input logic last);
        int       gap;
        in_item_t item;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        repeat (gap)
        begin
            @(negedge clk);
            b32_valid <= 1'b0;
        end
        item.in_char = ch;
        item.in_last = last;
        @(negedge clk);
        b32_valid <= 1'b1;
        b32_data  <= item;
        // payload holds while the block stalls
        @(posedge clk);
        while (b32_stall)
            @(posedge clk);
        predict_base64(ch, last);
        chars_sent++;
        if (last)
            messages_sent++;
    endtask

    task send_message(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_b32_char();
        int r;
        r = $urandom_range(0, 31);
        if (r < 26)
            return CH_UPPER_A + 8'(r);
        return CH_DIGIT_2 + 8'(r - 26);
    endfunction

    // mostly '=', sometimes any other non-alphabet code
    function automatic logic [7:0] rand_pad_char();
        logic [7:0] ch;
        if ($urandom_range(0, 2) != 0)
            return CH_EQUALS;
        do
            ch = 8'($urandom_range(0, 255));
        while (is_b32_char(ch));
        return ch;
    endfunction

    // one quantum with a legal pad pattern, optionally cut short by the end
    task send_random_quantum(input bit end_msg, input bit cut);
        int ndata;
        int nsend;
        case ($urandom_range(0, 5))
            0:       ndata = 7;
            1:       ndata = 5;
            2:       ndata = 4;
            3:       ndata = 2;
            default: ndata = 8;
        endcase
        nsend = cut ? $urandom_range(1, 7) : 8;
        for (int k = 0; k < nsend; k++)
            send_char((k < ndata) ? rand_b32_char() : rand_pad_char(),
                      end_msg && k == nsend - 1);
    endtask

    // park the sender until every owed character has come out
    task wait_drained();
        @(negedge clk);
        b32_valid <= 1'b0;
        while (expected_b64.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall bursts and an optional long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        b64_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                b64_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                b64_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                // start a stall burst; stall_left holds the rest of it
                b64_stall  <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end
            else
                b64_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every base64 transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_b64
        out_item_t want;
        if (rst_n && b64_valid && !b64_stall)
        begin
            if (expected_b64.size() == 0)
            begin
                $error("unexpected base64 transfer: out_char %h out_last %b",
                       b64_data.out_char, b64_data.out_last);
                error_count++;
            end
            else
            begin
                want = expected_b64.pop_front();
                results_checked++;
                if (b64_data.out_char !== want.out_char)
                begin
                    $error("out_char mismatch: expected %h, actual %h",
                           want.out_char, b64_data.out_char);
                    error_count++;
                end
                if (b64_data.out_last !== want.out_last)
                begin
                    $error("out_last mismatch: expected %b, actual %b",
                           want.out_last, b64_data.out_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every trimming case, mostly through short final quanta, plus range edges
    task test_directed();
        // lone pad: eight pads keep all five zero bytes, one '=' at the end
        send_char(8'hFF, 1'b1);
        // six pads keep one byte, "==" at the end
        send_message("MY");
        // four pads keep two bytes, "=" at the end
        send_message("MZXQ");
        // three pads keep three bytes, no padding
        send_message("7Z2AA");
        // one pad in a full quantum keeps four bytes
        send_message("7ZZZZZ2=");
        // codes just outside the alphabet all count as pads
        send_char(8'h00, 1'b0);
        send_char(CH_UPPER_Z + 8'd1, 1'b0);
        send_char(CH_UPPER_A - 8'd1, 1'b0);
        send_char(CH_DIGIT_2 - 8'd1, 1'b0);
        send_char(CH_DIGIT_7 + 8'd1, 1'b1);
    endtask

    // well-formed messages of one to four quanta, some ending mid-quantum
    task test_random_messages(input int budget);
        int stop_at;
        int nq;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            nq = $urandom_range(1, 4);
            for (int q = 0; q < nq; q++)
                send_random_quantum(q == nq - 1,
                                    q == nq - 1 && $urandom_range(0, 4) == 0);
        end
    endtask

    // any byte, message ends at random, closed off at the end
    task test_noise(input int budget);
        for (int i = 0; i < budget; i++)
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        send_char(rand_b32_char(), 1'b1);
    endtask

    // receiver holds off while the sender keeps offering a long message
    task test_backpressure();
        hold_left = HOLD_CYCLES;
        for (int q = 0; q < 8; q++)
            send_random_quantum(q == 7, 1'b0);
        wait_drained();
    endtask

    // no idling on either side for the closing stretch
    task test_streaming(input int budget);
        idle_on = 1'b0;
        test_random_messages(budget);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        b32_valid       = 1'b0;
        b32_data        = '0;
        idle_on         = 1'b1;
        hold_left       = 0;
        stall_left      = 0;
        error_count     = 0;
        chars_sent      = 0;
        messages_sent   = 0;
        results_checked = 0;
        clear_transcoder_state();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_messages(300);
        test_noise(100);
        test_backpressure();
        test_streaming(60);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_b64.size() != 0)
        begin
            $error("%0d base64 characters never arrived", expected_b64.size());
            error_count++;
        end

        $display("run covered %0d base32 characters in %0d messages, %0d base64 checked",
                 chars_sent, messages_sent, results_checked);
        $display("with all pad trims, pad noise, a %0d-cycle hold-off and gapless streaming",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("base32_to_base64_transcoder_core_test: clean");
        else
            $display("base32_to_base64_transcoder_core_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/b32b64_pkg.sv
hw/rtl/b32b64_front.sv
hw/rtl/b32b64_queue.sv
hw/rtl/b32b64_back.sv
hw/rtl/base32_to_base64_transcoder_core.sv
tb/base32_to_base64_transcoder_core_test.sv
